### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk; ASSERT_CLK is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same check, held also while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/bp_pkg.sv
// ---------------------------------------------------------------------------
// bp_pkg
// Shared constants, op codes and the byte job record of the bit packer.
// ---------------------------------------------------------------------------
package bp_pkg;

	localparam int ACC_BITS  = 32;
	localparam int BYTES     = ACC_BITS / 8;
	localparam int CNT_W     = $clog2(ACC_BITS + 1);
	localparam int SUM_W     = CNT_W + 1;
	localparam int NB_W      = $clog2(BYTES + 1);
	localparam int OP_W      = 2;
	localparam int FW_W      = 6;
	localparam int FV_W      = 32;
	localparam int FIELD_MAX = 32;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_FLUSH = 2'd1,
		OP_ALIGN = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Left-aligned word plus number of bytes to send from its top.
	typedef struct packed {
		logic [ACC_BITS-1:0] word;
		logic [NB_W-1:0]     nbytes;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### rtl/msb_first_bit_packer.sv
// Path: with the queue and sender idle, a job pushed at acceptance is written into the
// job queue, then its first byte into the output register, which raises out_valid.
// Throughput: one transaction per cycle while the two-entry job queue has room; each
// queued word, flush or aligned byte sends its bytes at one per cycle while out_ready holds.
// Reset: arst_n clears accumulator, pending count, queue and output valid.
// ---------------------------------------------------------------------------
// msb_first_bit_packer
// MSB-first variable-width field packer with byte output stream.
// ---------------------------------------------------------------------------
module msb_first_bit_packer import bp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] op,
	input  logic [FW_W-1:0] field_width,
	input  logic [FV_W-1:0] field_value,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      pop_job;

	bp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.field_width(field_width),
		.field_value(field_value),
		.q_stat     (q_stat),
		.push       (push),
		.push_job   (push_job)
	);

	bp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.q_stat  (q_stat)
	);

	bp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_job  (pop_job),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

### rtl/bp_front.sv
// ---------------------------------------------------------------------------
// bp_front
// Accepts transactions, packs fields into the accumulator and queues byte jobs
// for every word, every flush of a non-empty accumulator and every aligned byte.
// ---------------------------------------------------------------------------
module bp_front import bp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] op,
	input  logic [FW_W-1:0] field_width,
	input  logic [FV_W-1:0] field_value,
	input  q_status_t       q_stat,
	output logic            push,
	output job_t            push_job
);

	logic [ACC_BITS-1:0] acc_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [FW_W-1:0]     nc;
	logic [FV_W-1:0]     mask;
	logic [ACC_BITS-1:0] vx;
	logic [SUM_W-1:0]    total;
	logic [SUM_W-1:0]    r;
	logic                over;
	logic                accept;
	logic                upd;
	logic [ACC_BITS-1:0] acc_d;
	logic [CNT_W-1:0]    cnt_d;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		nc    = (field_width > FW_W'(FIELD_MAX)) ? FW_W'(FIELD_MAX) : field_width;
		mask  = (nc == FW_W'(FIELD_MAX)) ? '1 : ((FV_W'(1) << nc) - FV_W'(1));
		vx    = ACC_BITS'(field_value & mask);
		total = SUM_W'(cnt_q) + SUM_W'(nc);
		over  = total > SUM_W'(ACC_BITS);
		r     = total - SUM_W'(ACC_BITS);
	end

	always_comb begin
		push          = 1'b0;
		push_job.word   = acc_q | (vx >> r);
		push_job.nbytes = NB_W'(BYTES);
		upd           = 1'b0;
		acc_d         = acc_q;
		cnt_d         = cnt_q;
		case (op_t'(op))
			OP_PUT: begin
				if (nc != '0) begin
					upd = 1'b1;
					if (over) begin
						push  = 1'b1;
						acc_d = vx << (SUM_W'(ACC_BITS) - r);
						cnt_d = CNT_W'(r);
					end else begin
						acc_d = acc_q | (vx << (SUM_W'(ACC_BITS) - total));
						cnt_d = CNT_W'(total);
					end
				end
			end
			OP_FLUSH: begin
				upd             = 1'b1;
				push            = (cnt_q != '0);
				push_job.word   = acc_q;
				push_job.nbytes = NB_W'((SUM_W'(cnt_q) + SUM_W'(7)) >> 3);
				acc_d           = '0;
				cnt_d           = '0;
			end
			OP_ALIGN: begin
				upd             = 1'b1;
				push            = 1'b1;
				push_job.word   = {field_value[7:0], {(ACC_BITS-8){1'b0}}};
				push_job.nbytes = NB_W'(1);
				acc_d           = '0;
				cnt_d           = '0;
			end
			default: begin
				upd = 1'b0;
			end
		endcase
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept && upd) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

### rtl/bp_queue.sv
// ---------------------------------------------------------------------------
// bp_queue
// Short job queue between the packing front and the byte sender.
// ---------------------------------------------------------------------------
module bp_queue import bp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      pop_job,
	output q_status_t q_stat
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_job      = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### rtl/bp_back.sv
// ---------------------------------------------------------------------------
// bp_back
// Sends queued jobs one byte per cycle while out_ready allows, high byte
// first, through an output register; marks the final byte of each job.
// ---------------------------------------------------------------------------
module bp_back import bp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       pop_job,
	input  q_status_t  q_stat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last
);

	logic [ACC_BITS-1:0] word_q;
	logic [NB_W-1:0]     rem_q;
	logic                valid_q;
	logic [7:0]          byte_q;
	logic                last_q;
	logic                load;
	logic                busy;

	assign load      = !valid_q || out_ready;
	assign busy      = (rem_q != '0);
	assign pop       = load && !busy && !q_stat.empty;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else if (load) begin
			valid_q <= busy || !q_stat.empty;
			if (busy) begin
				rem_q <= rem_q - NB_W'(1);
			end else if (!q_stat.empty) begin
				rem_q <= pop_job.nbytes - NB_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (busy) begin
				byte_q <= word_q[ACC_BITS-1 -: 8];
				last_q <= (rem_q == NB_W'(1));
				word_q <= word_q << 8;
			end else if (!q_stat.empty) begin
				byte_q <= pop_job.word[ACC_BITS-1 -: 8];
				last_q <= (pop_job.nbytes == NB_W'(1));
				word_q <= pop_job.word << 8;
			end
		end
	end

endmodule

### rtl/bp_checker.sv
// ---------------------------------------------------------------------------
// bp_checker
// Port-level checks of the bit packer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bp_checker import bp_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic [OP_W-1:0] op,
	input logic [FW_W-1:0] field_width,
	input logic [FV_W-1:0] field_value,
	input logic            out_valid,
	input logic            out_ready,
	input logic [7:0]      out_byte,
	input logic            last
);

	// a full queue only happens while the sender holds a byte
	`ASSERT_CLK(a_full_implies_busy, !in_ready |-> out_valid, "queue full with sender idle")
	// bytes of one job go out without gaps
	`ASSERT_CLK(a_job_no_gap, out_valid && out_ready && !last |=> out_valid, "gap inside a job")
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped")
	`ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_byte) && $stable(last),
		"stalled output changed")
	// a waiting input transaction keeps its payload
	`ASSERT_CLK(a_in_hold, in_valid && !in_ready |=> in_valid && $stable({op, field_width, field_value}),
		"waiting input changed")

endmodule

bind msb_first_bit_packer bp_checker u_bp_checker (.*);

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MSB-first bit packer. Puts, flushes, aligned
// byte puts and ignored codes are sent with random gaps on both channels.
// A scoreboard packs every accepted transaction into its own accumulator and
// checks each output byte and its last flag in order.
// ---------------------------------------------------------------------------
module tb_top import bp_pkg::*;;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_ITEMS   = 305;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	class packer_scoreboard;
		logic [ACC_BITS-1:0] acc_bits;
		int unsigned         acc_count;
		packed_byte_t        expected_bytes[$];
		int unsigned         mismatches;
		int unsigned         bytes_checked;
		int unsigned         op_count[4];

		function new();
			acc_bits      = '0;
			acc_count     = 0;
			mismatches    = 0;
			bytes_checked = 0;
			foreach (op_count[i])
				op_count[i] = 0;
		endfunction

		function void queue_top_bytes(logic [ACC_BITS-1:0] word, int unsigned nbytes);
			packed_byte_t pb;
			for (int unsigned b = 0; b < nbytes; b++) begin
				pb.data = word[ACC_BITS-1-8*b -: 8];
				pb.last = (b + 1 == nbytes);
				expected_bytes.push_back(pb);
			end
		endfunction

		function void pack_transaction(logic [OP_W-1:0] o, logic [FW_W-1:0] fw,
				logic [FV_W-1:0] fv);
			int unsigned   n;
			int unsigned   total;
			int unsigned   r;
			logic [63:0]   v;
			logic [ACC_BITS-1:0] word;
			op_count[o]++;
			case (op_t'(o))
				OP_PUT: begin
					n = fw;
					if (n != 0) begin
						if (n > FIELD_MAX)
							n = FIELD_MAX;
						v = {32'd0, fv} & ((64'd1 << n) - 64'd1);
						total = acc_count + n;
						if (total > ACC_BITS) begin
							r    = total - ACC_BITS;
							word = acc_bits | ACC_BITS'(v >> r);
							queue_top_bytes(word, BYTES);
							acc_bits  = ACC_BITS'(v << (ACC_BITS - r));
							acc_count = r;
						end else begin
							acc_bits  = acc_bits | ACC_BITS'(v << (ACC_BITS - total));
							acc_count = total;
						end
					end
				end
				OP_FLUSH: begin
					if (acc_count != 0)
						queue_top_bytes(acc_bits, (acc_count + 7) / 8);
					acc_bits  = '0;
					acc_count = 0;
				end
				OP_ALIGN: begin
					acc_bits  = '0;
					acc_count = 0;
					queue_top_bytes({fv[7:0], {(ACC_BITS-8){1'b0}}}, 1);
				end
				default: ;
			endcase
		endfunction

		function void check_byte(logic [7:0] data, logic lst);
			packed_byte_t pb;
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected byte %02h last %0b", data, lst);
				return;
			end
			pb = expected_bytes.pop_front();
			if (data !== pb.data || lst !== pb.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: byte %0d expected %02h last %0b, got %02h last %0b",
						bytes_checked, pb.data, pb.last, data, lst);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [OP_W-1:0] op;
	logic [FW_W-1:0] field_width;
	logic [FV_W-1:0] field_value;
	logic            out_valid;
	logic            out_ready;
	logic [7:0]      out_byte;
	logic            last;

	packer_scoreboard sb;
	bit               calm;
	int unsigned      idle_cycles;
	int unsigned      accepted_in;

	msb_first_bit_packer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.field_width (field_width),
		.field_value (field_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_NOP;
		field_width = '0;
		field_value = '0;
		out_ready   = 1'b0;
		calm        = 1'b0;
		idle_cycles = 0;
		accepted_in = 0;
		sb          = new();
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= calm || ($urandom_range(99) >= 13);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.pack_transaction(op, field_width, field_value);
			accepted_in++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, last);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: watchdog, no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("msb_first_bit_packer regression: fail");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] o, input logic [FW_W-1:0] fw,
			input logic [FV_W-1:0] fv);
		while (!calm && $urandom_range(99) < 13) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		op          <= o;
		field_width <= fw;
		field_value <= fv;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic directed_items();
		send_item(OP_PUT,   6'd1,  32'h0000_0001);
		send_item(OP_PUT,   6'd32, 32'hFFFF_FFFF);
		send_item(OP_FLUSH, 6'd0,  32'h0);
		send_item(OP_FLUSH, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_PUT,   6'd0,  32'hFFFF_FFFF);
		send_item(OP_PUT,   6'd63, 32'h8000_0001);
		send_item(OP_PUT,   6'd33, 32'hDEAD_BEEF);
		send_item(OP_FLUSH, 6'd5,  32'h0);
		send_item(OP_PUT,   6'd32, 32'h1234_5678);
		send_item(OP_FLUSH, 6'd0,  32'h0);
		send_item(OP_PUT,   6'd8,  32'hFFFF_FFA5);
		send_item(OP_PUT,   6'd24, 32'h00C3_3C5A);
		send_item(OP_PUT,   6'd1,  32'h0000_0001);
		send_item(OP_PUT,   6'd7,  32'h0000_005D);
		send_item(OP_ALIGN, 6'd3,  32'h1234_56FF);
		send_item(OP_PUT,   6'd5,  32'h0000_001F);
		send_item(OP_NOP,   6'd63, 32'hFFFF_FFFF);
		send_item(OP_FLUSH, 6'd0,  32'h0);
		send_item(OP_PUT,   6'd9,  32'h0000_01AB);
		send_item(OP_FLUSH, 6'd0,  32'h0);
		send_item(OP_PUT,   6'd17, 32'hFFFE_5555);
		send_item(OP_FLUSH, 6'd0,  32'h0);
		send_item(OP_PUT,   6'd31, 32'h0000_0000);
		send_item(OP_PUT,   6'd32, 32'hA5A5_5A5A);
		send_item(OP_ALIGN, 6'd0,  32'h0000_0000);
	endtask

	task automatic random_items();
		int unsigned     effective;
		int unsigned     idx;
		int unsigned     pick;
		logic [OP_W-1:0] o;
		logic [FW_W-1:0] fw;
		logic [FV_W-1:0] fv;
		effective = 0;
		idx       = 0;
		while (effective < RANDOM_ITEMS) begin
			calm = (idx >= 120 && idx < 200);
			pick = $urandom_range(99);
			if (pick < 70)
				o = OP_PUT;
			else if (pick < 84)
				o = OP_FLUSH;
			else if (pick < 94)
				o = OP_ALIGN;
			else
				o = OP_NOP;
			pick = $urandom_range(99);
			if (o != OP_PUT)
				fw = FW_W'($urandom_range(63, 0));
			else if (pick < 4)
				fw = '0;
			else if (pick < 8)
				fw = FW_W'($urandom_range(63, 33));
			else if (pick < 20)
				fw = FW_W'($urandom_range(32, 25));
			else
				fw = FW_W'($urandom_range(32, 1));
			pick = $urandom_range(99);
			if (pick < 10)
				fv = '1;
			else if (pick < 15)
				fv = '0;
			else
				fv = $urandom;
			if (!(o == OP_NOP || (o == OP_PUT && fw == 0)))
				effective++;
			send_item(o, fw, fv);
			idx++;
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		directed_items();
		random_items();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_bytes.size() != 0)
			$display("ERROR: %0d expected bytes never arrived", sb.expected_bytes.size());
		$display("Covered %0d transactions: %0d puts, %0d flushes, %0d aligned bytes, %0d nops.",
			accepted_in, sb.op_count[OP_PUT], sb.op_count[OP_FLUSH],
			sb.op_count[OP_ALIGN], sb.op_count[OP_NOP]);
		$display("Checked %0d output bytes, %0d mismatches.", sb.bytes_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
			$display("msb_first_bit_packer regression: pass");
		else
			$display("msb_first_bit_packer regression: fail");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/bp_pkg.sv
rtl/bp_front.sv
rtl/bp_queue.sv
rtl/bp_back.sv
rtl/msb_first_bit_packer.sv
rtl/bp_checker.sv
test/tb_top.sv
